FILE: design/mte_pkg.sv
// ----------------------------------------------------------------------------
// mte_pkg
// Shared types and codes for the multitape Turing engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package mte_pkg;

    localparam logic [2:0] FUNC_LOAD  = 3'd0;
    localparam logic [2:0] FUNC_WRITE = 3'd1;
    localparam logic [2:0] FUNC_RUN   = 3'd2;
    localparam logic [2:0] FUNC_READ  = 3'd3;
    localparam logic [2:0] FUNC_CLEAR = 3'd4;

    localparam logic [2:0] CFG_INITIAL_STATE = 3'd0;
    localparam logic [2:0] CFG_BLANK_SYMBOL  = 3'd1;
    localparam logic [2:0] CFG_TAPE_COUNT    = 3'd2;
    localparam logic [2:0] CFG_ENTRY_COUNT   = 3'd3;
    localparam logic [2:0] CFG_STEP_LIMIT    = 3'd4;

    localparam logic [1:0] MOVE_LEFT  = 2'd1;
    localparam logic [1:0] MOVE_RIGHT = 2'd2;

    localparam logic [1:0] STOP_NO_MATCH = 2'd0;
    localparam logic [1:0] STOP_LIMIT    = 2'd1;
    localparam logic [1:0] STOP_WINDOW   = 2'd2;

    localparam logic RESULT_RUN  = 1'b0;
    localparam logic RESULT_READ = 1'b1;

    localparam logic [7:0] WILDCARD = 8'd42;

    typedef struct packed {
        logic [7:0] match_state;
        logic [7:0] next_state;
        logic [7:0] expect_first;
        logic [7:0] expect_second;
        logic [7:0] write_first;
        logic [7:0] write_second;
        logic [1:0] move_first;
        logic [1:0] move_second;
    } entry_t;

    typedef struct packed {
        logic hit;
        logic left;
    } step_flags_t;

endpackage

`default_nettype wire

FILE: design/mte_ram.sv
// ----------------------------------------------------------------------------
// mte_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mte_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                   aclk,
    input  wire logic                                   we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                       wdata,
    input  wire logic                                   re,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

FILE: design/mte_step_unit.sv
// ----------------------------------------------------------------------------
// mte_step_unit
// Entry match test and head move for one transition.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mte_step_unit #(
    parameter int HW   = 11,
    parameter int HALF = 512
) (
    input  wire logic                  [7:0] cur_state,
    input  wire mte_pkg::entry_t             entry,
    input  wire logic                  [7:0] sym0,
    input  wire logic                  [7:0] sym1,
    input  wire logic                  [7:0] blank,
    input  wire logic                        two_tapes,
    input  wire logic signed [HW-1:0]        head0,
    input  wire logic signed [HW-1:0]        head1,
    output logic signed      [HW-1:0]        head0_next,
    output logic signed      [HW-1:0]        head1_next,
    output mte_pkg::step_flags_t             flags
);

    localparam int PW = HW + 1;
    localparam logic signed [PW-1:0] WIN_LO = PW'(-HALF);
    localparam logic signed [PW-1:0] WIN_HI = PW'(HALF - 1);

    logic ok0, ok1;
    logic signed [PW-1:0] p0, p1;
    logic in0, in1;

    always_comb begin
        ok0 = (entry.expect_first == mte_pkg::WILDCARD) ? (sym0 != blank)
                                                         : (sym0 == entry.expect_first);
        ok1 = (entry.expect_second == mte_pkg::WILDCARD) ? (sym1 != blank)
                                                          : (sym1 == entry.expect_second);
        flags.hit = (entry.match_state == cur_state) && ok0 && (ok1 || !two_tapes);

        p0 = PW'(head0);
        case (entry.move_first)
            mte_pkg::MOVE_LEFT:  p0 = PW'(head0) - PW'(1);
            mte_pkg::MOVE_RIGHT: p0 = PW'(head0) + PW'(1);
            default:             p0 = PW'(head0);
        endcase
        p1 = PW'(head1);
        case (entry.move_second)
            mte_pkg::MOVE_LEFT:  p1 = PW'(head1) - PW'(1);
            mte_pkg::MOVE_RIGHT: p1 = PW'(head1) + PW'(1);
            default:             p1 = PW'(head1);
        endcase
        in0 = (p0 >= WIN_LO) && (p0 <= WIN_HI);
        in1 = (p1 >= WIN_LO) && (p1 <= WIN_HI);

        head0_next = in0 ? p0[HW-1:0] : head0;
        head1_next = (two_tapes && in1) ? p1[HW-1:0] : head1;
        flags.left = !in0 || (two_tapes && !in1);
    end

endmodule

`default_nettype wire

FILE: design/multitape_turing_engine.sv
// ----------------------------------------------------------------------------
// multitape_turing_engine
// Multitape Turing machine engine with table scan sequencer.
// ----------------------------------------------------------------------------
// A load or cell write request is done as it is accepted; a clear request then
// blanks the tapes in a pass over all TAPE_CELLS cells, and the same pass runs
// after reset. A cell read captures the cell in ST_RDCAP before ST_EMIT. A run
// first blanks the second tape (when TAPES is above 1), then each step fetches
// the cells under the heads, reads and compares the table entries in turn up to
// and including the hit (one table RAM read port, one compare unit), and then
// applies the entry. The ready output is low while any request is at work.
`timescale 1ns / 1ps
`default_nettype none

module multitape_turing_engine #(
    parameter int TAPES         = 2,
    parameter int TABLE_ENTRIES = 256,
    parameter int TAPE_CELLS    = 1024
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              cfg_wr_en,
    input  wire logic        [2:0] cfg_index,
    input  wire logic       [31:0] cfg_wdata,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire logic        [2:0] s_func,
    input  wire logic        [7:0] s_entry_index,
    input  wire logic        [7:0] s_match_state,
    input  wire logic        [7:0] s_next_state,
    input  wire logic        [7:0] s_expect_first,
    input  wire logic        [7:0] s_expect_second,
    input  wire logic        [7:0] s_write_first,
    input  wire logic        [7:0] s_write_second,
    input  wire logic        [1:0] s_move_first,
    input  wire logic        [1:0] s_move_second,
    input  wire logic signed [9:0] s_cell_position,
    input  wire logic        [7:0] s_cell_symbol,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output logic                   m_result_kind,
    output logic             [7:0] m_final_state,
    output logic            [31:0] m_steps_taken,
    output logic             [1:0] m_stop_reason,
    output logic signed      [9:0] m_first_head,
    output logic signed      [9:0] m_second_head,
    output logic             [7:0] m_read_symbol
);

    localparam int AW   = $clog2(TAPE_CELLS);
    localparam int HW   = AW + 1;
    localparam int HALF = TAPE_CELLS / 2;
    localparam int CW   = (HW > 10 ? HW : 10) + 1;
    localparam int TIW  = TABLE_ENTRIES > 1 ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CNTW = $clog2(TABLE_ENTRIES + 1) > 9 ? $clog2(TABLE_ENTRIES + 1) : 9;
    localparam logic signed [CW-1:0] WIN_LO = CW'(-HALF);
    localparam logic signed [CW-1:0] WIN_HI = CW'(HALF - 1);

    typedef enum logic [8:0] {
        ST_IDLE  = 9'b000000001,
        ST_CLEAR = 9'b000000010,
        ST_CHECK = 9'b000000100,
        ST_SYM   = 9'b000001000,
        ST_TREAD = 9'b000010000,
        ST_TCMP  = 9'b000100000,
        ST_APPLY = 9'b001000000,
        ST_RDCAP = 9'b010000000,
        ST_EMIT  = 9'b100000000
    } state_t;

    state_t state_reg, state_next;

    logic [7:0]  initial_state_reg, blank_symbol_reg;
    logic [1:0]  tape_count_reg;
    logic [8:0]  entry_count_reg;
    logic [31:0] step_limit_reg;

    logic                   clr_all_reg, clr_all_next;
    logic [AW-1:0]          clr_cnt_reg, clr_cnt_next;
    logic [7:0]             mstate_reg, mstate_next;
    logic [31:0]            step_reg, step_next;
    logic signed [HW-1:0]   head0_reg, head0_next, head1_reg, head1_next;
    logic [7:0]             sym0_reg, sym0_next, sym1_reg, sym1_next;
    logic [CNTW-1:0]        e_reg, e_next;
    logic [1:0]             reason_reg, reason_next;
    logic                   kind_reg, kind_next;
    logic                   rd_in_reg, rd_in_next;
    logic [7:0]             rsym_reg, rsym_next;

    logic                   m_valid_reg;
    logic                   out_load;

    logic                   accept;
    logic                   two_tapes;
    logic [31:0]            limit_eff;
    logic [CNTW-1:0]        cnt_eff, e_inc;
    logic signed [CW-1:0]   pos_ext, pos_off, h0_off, h1_off;
    logic                   pos_in;
    logic [AW-1:0]          pos_idx, h0_idx, h1_idx;

    logic                   tab_we, tab_re;
    logic [TIW-1:0]         tab_waddr, tab_raddr;
    mte_pkg::entry_t        tab_wdata, tab_rdata;

    logic                   t0_we, t0_re, t1_we, t1_re;
    logic [AW-1:0]          t0_waddr, t0_raddr, t1_waddr, t1_raddr;
    logic [8:0]             t0_wdata, t0_rdata, t1_wdata, t1_rdata;
    logic [7:0]             t0_sym, t1_sym;

    logic signed [HW-1:0]   su_head0, su_head1;
    mte_pkg::step_flags_t   su_flags;
    logic signed [CW-1:0]   h0_out, h1_out;

    assign s_ready   = (state_reg == ST_IDLE);
    assign accept    = s_valid && s_ready;
    assign two_tapes = (TAPES > 1) && tape_count_reg[1];
    assign limit_eff = (step_limit_reg == 32'd0) ? 32'hFFFF_FFFF : step_limit_reg;
    assign cnt_eff   = (CNTW'(entry_count_reg) > CNTW'(TABLE_ENTRIES))
                     ? CNTW'(TABLE_ENTRIES) : CNTW'(entry_count_reg);
    assign e_inc     = e_reg + CNTW'(1);

    assign pos_ext = CW'(s_cell_position);
    assign pos_off = pos_ext + CW'(HALF);
    assign pos_in  = (pos_ext >= WIN_LO) && (pos_ext <= WIN_HI);
    assign pos_idx = pos_off[AW-1:0];
    assign h0_off  = CW'(head0_reg) + CW'(HALF);
    assign h1_off  = CW'(head1_reg) + CW'(HALF);
    assign h0_idx  = h0_off[AW-1:0];
    assign h1_idx  = h1_off[AW-1:0];

    assign t0_sym = t0_rdata[8] ? t0_rdata[7:0] : blank_symbol_reg;
    assign t1_sym = t1_rdata[8] ? t1_rdata[7:0] : blank_symbol_reg;

    // table
    assign tab_we    = accept && (s_func == mte_pkg::FUNC_LOAD)
                    && (32'(s_entry_index) < 32'(TABLE_ENTRIES));
    assign tab_waddr = TIW'(s_entry_index);
    assign tab_wdata = '{match_state:   s_match_state,
                         next_state:    s_next_state,
                         expect_first:  s_expect_first,
                         expect_second: s_expect_second,
                         write_first:   s_write_first,
                         write_second:  s_write_second,
                         move_first:    s_move_first,
                         move_second:   s_move_second};
    assign tab_re    = (state_reg == ST_TREAD);
    assign tab_raddr = e_reg[TIW-1:0];

    mte_ram #(
        .WIDTH ($bits(mte_pkg::entry_t)),
        .DEPTH (TABLE_ENTRIES)
    ) u_table (
        .aclk  (aclk),
        .we    (tab_we),
        .waddr (tab_waddr),
        .wdata (tab_wdata),
        .re    (tab_re),
        .raddr (tab_raddr),
        .rdata (tab_rdata)
    );

    // tape ports
    always_comb begin
        t0_we    = 1'b0;
        t0_waddr = h0_idx;
        t0_wdata = {1'b1, tab_rdata.write_first};
        t0_re    = 1'b0;
        t0_raddr = h0_idx;
        t1_we    = 1'b0;
        t1_waddr = h1_idx;
        t1_wdata = {1'b1, tab_rdata.write_second};
        t1_re    = (state_reg == ST_CHECK);
        t1_raddr = h1_idx;
        case (state_reg)
            ST_IDLE: begin
                t0_we    = accept && (s_func == mte_pkg::FUNC_WRITE) && pos_in;
                t0_waddr = pos_idx;
                t0_wdata = {1'b1, s_cell_symbol};
                t0_re    = accept && (s_func == mte_pkg::FUNC_READ);
                t0_raddr = pos_idx;
            end
            ST_CLEAR: begin
                t0_we    = clr_all_reg;
                t0_waddr = clr_cnt_reg;
                t0_wdata = '0;
                t1_we    = 1'b1;
                t1_waddr = clr_cnt_reg;
                t1_wdata = '0;
            end
            ST_CHECK: begin
                t0_re = 1'b1;
            end
            ST_APPLY: begin
                t0_we = (tab_rdata.write_first != mte_pkg::WILDCARD);
                t1_we = two_tapes && (tab_rdata.write_second != mte_pkg::WILDCARD);
            end
            default: begin
                t0_we = 1'b0;
            end
        endcase
    end

    mte_ram #(
        .WIDTH (9),
        .DEPTH (TAPE_CELLS)
    ) u_tape0 (
        .aclk  (aclk),
        .we    (t0_we),
        .waddr (t0_waddr),
        .wdata (t0_wdata),
        .re    (t0_re),
        .raddr (t0_raddr),
        .rdata (t0_rdata)
    );

    if (TAPES > 1) begin : g_tape1
        mte_ram #(
            .WIDTH (9),
            .DEPTH (TAPE_CELLS)
        ) u_tape1 (
            .aclk  (aclk),
            .we    (t1_we),
            .waddr (t1_waddr),
            .wdata (t1_wdata),
            .re    (t1_re),
            .raddr (t1_raddr),
            .rdata (t1_rdata)
        );
    end else begin : g_no_tape1
        assign t1_rdata = '0;
    end

    mte_step_unit #(
        .HW   (HW),
        .HALF (HALF)
    ) u_step (
        .cur_state  (mstate_reg),
        .entry      (tab_rdata),
        .sym0       (sym0_reg),
        .sym1       (sym1_reg),
        .blank      (blank_symbol_reg),
        .two_tapes  (two_tapes),
        .head0      (head0_reg),
        .head1      (head1_reg),
        .head0_next (su_head0),
        .head1_next (su_head1),
        .flags      (su_flags)
    );

    // sequencer
    always_comb begin
        state_next   = state_reg;
        clr_all_next = clr_all_reg;
        clr_cnt_next = clr_cnt_reg;
        mstate_next  = mstate_reg;
        step_next    = step_reg;
        head0_next   = head0_reg;
        head1_next   = head1_reg;
        sym0_next    = sym0_reg;
        sym1_next    = sym1_reg;
        e_next       = e_reg;
        reason_next  = reason_reg;
        kind_next    = kind_reg;
        rd_in_next   = rd_in_reg;
        rsym_next    = rsym_reg;
        out_load     = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    case (s_func)
                        mte_pkg::FUNC_RUN: begin
                            head0_next   = '0;
                            head1_next   = '0;
                            mstate_next  = initial_state_reg;
                            step_next    = '0;
                            kind_next    = mte_pkg::RESULT_RUN;
                            clr_all_next = 1'b0;
                            clr_cnt_next = '0;
                            state_next   = (TAPES > 1) ? ST_CLEAR : ST_CHECK;
                        end
                        mte_pkg::FUNC_READ: begin
                            rd_in_next = pos_in;
                            kind_next  = mte_pkg::RESULT_READ;
                            state_next = ST_RDCAP;
                        end
                        mte_pkg::FUNC_CLEAR: begin
                            clr_all_next = 1'b1;
                            clr_cnt_next = '0;
                            state_next   = ST_CLEAR;
                        end
                        default: begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_CLEAR: begin
                clr_cnt_next = clr_cnt_reg + AW'(1);
                if (clr_cnt_reg == AW'(TAPE_CELLS - 1)) begin
                    state_next = clr_all_reg ? ST_IDLE : ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (step_reg >= limit_eff) begin
                    reason_next = mte_pkg::STOP_LIMIT;
                    state_next  = ST_EMIT;
                end else begin
                    state_next = ST_SYM;
                end
            end
            ST_SYM: begin
                sym0_next = t0_sym;
                sym1_next = t1_sym;
                e_next    = '0;
                if (cnt_eff == '0) begin
                    reason_next = mte_pkg::STOP_NO_MATCH;
                    state_next  = ST_EMIT;
                end else begin
                    state_next = ST_TREAD;
                end
            end
            ST_TREAD: begin
                state_next = ST_TCMP;
            end
            ST_TCMP: begin
                if (su_flags.hit) begin
                    state_next = ST_APPLY;
                end else if (e_inc == cnt_eff) begin
                    reason_next = mte_pkg::STOP_NO_MATCH;
                    state_next  = ST_EMIT;
                end else begin
                    e_next     = e_inc;
                    state_next = ST_TREAD;
                end
            end
            ST_APPLY: begin
                head0_next  = su_head0;
                head1_next  = su_head1;
                mstate_next = tab_rdata.next_state;
                step_next   = step_reg + 32'd1;
                if (su_flags.left) begin
                    reason_next = mte_pkg::STOP_WINDOW;
                    state_next  = ST_EMIT;
                end else begin
                    state_next = ST_CHECK;
                end
            end
            ST_RDCAP: begin
                rsym_next  = rd_in_reg ? t0_sym : blank_symbol_reg;
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (!m_valid_reg || m_ready) begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg         <= ST_CLEAR;
            clr_all_reg       <= 1'b1;
            clr_cnt_reg       <= '0;
            mstate_reg        <= '0;
            step_reg          <= '0;
            head0_reg         <= '0;
            head1_reg         <= '0;
            e_reg             <= '0;
            m_valid_reg       <= 1'b0;
            initial_state_reg <= '0;
            blank_symbol_reg  <= '0;
            tape_count_reg    <= 2'd1;
            entry_count_reg   <= '0;
            step_limit_reg    <= '0;
        end else begin
            state_reg   <= state_next;
            clr_all_reg <= clr_all_next;
            clr_cnt_reg <= clr_cnt_next;
            mstate_reg  <= mstate_next;
            step_reg    <= step_next;
            head0_reg   <= head0_next;
            head1_reg   <= head1_next;
            e_reg       <= e_next;
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (cfg_wr_en) begin
                case (cfg_index)
                    mte_pkg::CFG_INITIAL_STATE: initial_state_reg <= cfg_wdata[7:0];
                    mte_pkg::CFG_BLANK_SYMBOL:  blank_symbol_reg  <= cfg_wdata[7:0];
                    mte_pkg::CFG_TAPE_COUNT:    tape_count_reg    <= cfg_wdata[1:0];
                    mte_pkg::CFG_ENTRY_COUNT:   entry_count_reg   <= cfg_wdata[8:0];
                    mte_pkg::CFG_STEP_LIMIT:    step_limit_reg    <= cfg_wdata;
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        sym0_reg   <= sym0_next;
        sym1_reg   <= sym1_next;
        reason_reg <= reason_next;
        kind_reg   <= kind_next;
        rd_in_reg  <= rd_in_next;
        rsym_reg   <= rsym_next;
    end

    // result register
    assign h0_out = CW'(head0_reg);
    assign h1_out = CW'(head1_reg);

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_result_kind <= kind_reg;
            if (kind_reg == mte_pkg::RESULT_READ) begin
                m_final_state <= '0;
                m_steps_taken <= '0;
                m_stop_reason <= '0;
                m_first_head  <= '0;
                m_second_head <= '0;
                m_read_symbol <= rsym_reg;
            end else begin
                m_final_state <= mstate_reg;
                m_steps_taken <= step_reg;
                m_stop_reason <= reason_reg;
                m_first_head  <= h0_out[9:0];
                m_second_head <= h1_out[9:0];
                m_read_symbol <= '0;
            end
        end
    end

    assign m_valid = m_valid_reg;

    // checks
    a_head0_window: assert property (@(posedge aclk) disable iff (!aresetn)
        (h0_out >= WIN_LO) && (h0_out <= WIN_HI))
        else $error("first head outside tape window");

    a_head1_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CHECK) && !two_tapes |-> (head1_reg == '0))
        else $error("inactive second head moved");

    a_step_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CHECK) |-> (step_reg <= limit_eff))
        else $error("step count passed the limit");

    a_scan_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_TCMP) |-> (e_reg < cnt_eff))
        else $error("table scan past entry count");

endmodule

`default_nettype wire

FILE: dv/tb_multitape_turing_engine.sv
// ----------------------------------------------------------------------------
// tb_multitape_turing_engine
// Self-checking bench for the multitape Turing engine: table loads, cell
// access, tape clears and machine runs are predicted in the bench and every
// result is compared field by field, under random idling on both channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_multitape_turing_engine;

    localparam int WDOG_LIMIT = 200000;
    localparam int SETTLE     = 1100;
    localparam int HALF       = 512;

    typedef struct {
        logic [2:0]        func;
        logic [7:0]        idx, mst, nst, ex1, ex2, wr1, wr2;
        logic [1:0]        mv1, mv2;
        logic signed [9:0] pos;
        logic [7:0]        sym;
    } req_t;

    typedef struct {
        logic        kind;
        logic [7:0]  state;
        logic [31:0] steps;
        logic [1:0]  reason;
        logic [9:0]  head1, head2;
        logic [7:0]  sym;
    } result_t;

    logic aclk, aresetn;
    logic cfg_wr_en;
    logic [2:0] cfg_index;
    logic [31:0] cfg_wdata;
    logic s_valid, s_ready;
    logic [2:0] s_func;
    logic [7:0] s_entry_index, s_match_state, s_next_state;
    logic [7:0] s_expect_first, s_expect_second, s_write_first, s_write_second;
    logic [1:0] s_move_first, s_move_second;
    logic signed [9:0] s_cell_position;
    logic [7:0] s_cell_symbol;
    logic m_valid, m_ready, m_result_kind;
    logic [7:0] m_final_state, m_read_symbol;
    logic [31:0] m_steps_taken;
    logic [1:0] m_stop_reason;
    logic signed [9:0] m_first_head, m_second_head;

    multitape_turing_engine dut (.*);

    // bench copy of the machine
    mte_pkg::entry_t prog [256];
    logic [7:0] tape_sym [2][1024];
    bit         tape_set [2][1024];
    logic [7:0] init_state_r, blank_r;
    logic [1:0] tapes_r;
    logic [8:0] entries_r;
    logic [31:0] limit_r;

    result_t result_q[$];
    int errors, n_items, n_runs, n_reads, rx_wait, rx_long, idle_cycles;
    bit no_idle;

    initial begin
        aclk = 0;
        forever #4 aclk = ~aclk;
    end

    function automatic logic [7:0] tape_rd(int t, int p);
        return tape_set[t][p + HALF] ? tape_sym[t][p + HALF] : blank_r;
    endfunction

    function automatic result_t run_machine();
        result_t res;
        int h[2], hit, count, nt, p;
        logic [31:0] lim;
        logic [7:0] st, s, x, w;
        logic [1:0] mv;
        bit ok, left;
        h[0] = 0; h[1] = 0;
        st = init_state_r;
        res = '{default: 0};
        lim = (limit_r != 0) ? limit_r : 32'hFFFF_FFFF;
        count = (entries_r > 256) ? 256 : entries_r;
        nt = (tapes_r == 0) ? 1 : (tapes_r == 3) ? 2 : tapes_r;
        for (int i = 0; i < 1024; i++) tape_set[1][i] = 0;
        while (1) begin
            if (res.steps >= lim) begin
                res.reason = mte_pkg::STOP_LIMIT;
                break;
            end
            hit = -1;
            for (int e = 0; e < count; e++) begin
                if (prog[e].match_state != st) continue;
                ok = 1;
                for (int t = 0; t < nt; t++) begin
                    s = tape_rd(t, h[t]);
                    x = (t == 0) ? prog[e].expect_first : prog[e].expect_second;
                    if (x == mte_pkg::WILDCARD ? s == blank_r : s != x) ok = 0;
                end
                if (ok) begin
                    hit = e;
                    break;
                end
            end
            if (hit < 0) begin
                res.reason = mte_pkg::STOP_NO_MATCH;
                break;
            end
            left = 0;
            for (int t = 0; t < nt; t++) begin
                p = h[t];
                w = (t == 0) ? prog[hit].write_first : prog[hit].write_second;
                mv = (t == 0) ? prog[hit].move_first : prog[hit].move_second;
                if (w != mte_pkg::WILDCARD) begin
                    tape_sym[t][p + HALF] = w;
                    tape_set[t][p + HALF] = 1;
                end
                if (mv == mte_pkg::MOVE_LEFT) p--;
                else if (mv == mte_pkg::MOVE_RIGHT) p++;
                if (p >= -HALF && p < HALF) h[t] = p;
                else left = 1;
            end
            st = prog[hit].next_state;
            res.steps++;
            if (left) begin
                res.reason = mte_pkg::STOP_WINDOW;
                break;
            end
        end
        res.kind = mte_pkg::RESULT_RUN;
        res.state = st;
        res.head1 = h[0][9:0];
        res.head2 = h[1][9:0];
        return res;
    endfunction

    task automatic predict(req_t r);
        result_t res;
        int p;
        p = int'(r.pos);
        case (r.func)
            mte_pkg::FUNC_LOAD:
                prog[r.idx] = '{r.mst, r.nst, r.ex1, r.ex2, r.wr1, r.wr2, r.mv1, r.mv2};
            mte_pkg::FUNC_WRITE: begin
                tape_sym[0][p + HALF] = r.sym;
                tape_set[0][p + HALF] = 1;
            end
            mte_pkg::FUNC_RUN: begin
                result_q = {result_q, run_machine()};
                n_runs++;
            end
            mte_pkg::FUNC_READ: begin
                res = '{default: 0};
                res.kind = mte_pkg::RESULT_READ;
                res.sym = tape_rd(0, p);
                result_q = {result_q, res};
                n_reads++;
            end
            mte_pkg::FUNC_CLEAR: begin
                foreach (tape_set[t, i]) tape_set[t][i] = 0;
            end
            default: ;
        endcase
    endtask

    task automatic report(string what, logic [31:0] got, logic [31:0] want);
        $display("[%0t] mismatch %s: got %0h expected %0h", $realtime, what, got, want);
        errors++;
    endtask

    always @(posedge aclk) begin
        result_t w;
        if (aresetn && m_valid && m_ready) begin
            if (result_q.size() == 0) begin
                report("unexpected result", m_result_kind, 0);
            end else begin
                w = result_q.pop_front();
                if (m_result_kind !== w.kind) report("result_kind", m_result_kind, w.kind);
                if (m_final_state !== w.state) report("final_state", m_final_state, w.state);
                if (m_steps_taken !== w.steps) report("steps_taken", m_steps_taken, w.steps);
                if (m_stop_reason !== w.reason) report("stop_reason", m_stop_reason, w.reason);
                if (m_first_head !== w.head1) report("first_head", m_first_head, w.head1);
                if (m_second_head !== w.head2) report("second_head", m_second_head, w.head2);
                if (m_read_symbol !== w.sym) report("read_symbol", m_read_symbol, w.sym);
            end
            rx_wait = no_idle ? 0 : $urandom_range(0, 3);
        end
    end

    // receiver
    always @(negedge aclk) begin
        if (rx_long > 0) begin
            m_ready <= 1'b0;
            rx_long--;
        end else if (rx_wait > 0) begin
            m_ready <= 1'b0;
            rx_wait--;
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles = 0;
        else idle_cycles++;
        if (idle_cycles >= WDOG_LIMIT) begin
            $display("watchdog: no progress for %0d cycles", WDOG_LIMIT);
            $display("tb_multitape_turing_engine: FAIL");
            $finish;
        end
    end

    task automatic send(req_t r);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 3);
        repeat (gap) begin
            @(negedge aclk);
            s_valid <= 1'b0;
        end
        @(negedge aclk);
        s_valid <= 1'b1;
        s_func <= r.func;
        s_entry_index <= r.idx;
        s_match_state <= r.mst;
        s_next_state <= r.nst;
        s_expect_first <= r.ex1;
        s_expect_second <= r.ex2;
        s_write_first <= r.wr1;
        s_write_second <= r.wr2;
        s_move_first <= r.mv1;
        s_move_second <= r.mv2;
        s_cell_position <= r.pos;
        s_cell_symbol <= r.sym;
        do @(posedge aclk); while (!s_ready);
        predict(r);
        n_items++;
    endtask

    function automatic req_t noise_req(logic [2:0] func);
        req_t r;
        r.func = func;
        r.idx = $urandom; r.mst = $urandom; r.nst = $urandom;
        r.ex1 = $urandom; r.ex2 = $urandom; r.wr1 = $urandom; r.wr2 = $urandom;
        r.mv1 = $urandom; r.mv2 = $urandom; r.pos = $urandom; r.sym = $urandom;
        return r;
    endfunction

    task automatic load(logic [7:0] idx, logic [7:0] mst, logic [7:0] nst,
                        logic [7:0] ex1, logic [7:0] ex2, logic [7:0] wr1,
                        logic [7:0] wr2, logic [1:0] mv1, logic [1:0] mv2);
        req_t r;
        r = noise_req(mte_pkg::FUNC_LOAD);
        r.idx = idx; r.mst = mst; r.nst = nst; r.ex1 = ex1; r.ex2 = ex2;
        r.wr1 = wr1; r.wr2 = wr2; r.mv1 = mv1; r.mv2 = mv2;
        send(r);
    endtask

    task automatic cell_req(logic [2:0] func, int pos, logic [7:0] sym);
        req_t r;
        r = noise_req(func);
        r.pos = pos[9:0];
        r.sym = sym;
        send(r);
    endtask

    task automatic drain();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (result_q.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic cfg_write(logic [2:0] idx, logic [31:0] data);
        @(negedge aclk);
        s_valid <= 1'b0;
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            mte_pkg::CFG_INITIAL_STATE: init_state_r = data[7:0];
            mte_pkg::CFG_BLANK_SYMBOL:  blank_r = data[7:0];
            mte_pkg::CFG_TAPE_COUNT:    tapes_r = data[1:0];
            mte_pkg::CFG_ENTRY_COUNT:   entries_r = data[8:0];
            mte_pkg::CFG_STEP_LIMIT:    limit_r = data;
            default: ;
        endcase
    endtask

    task automatic configure(logic [7:0] init, logic [7:0] blank, logic [1:0] tapes,
                             logic [8:0] entries, logic [31:0] limit);
        cfg_write(mte_pkg::CFG_INITIAL_STATE, init);
        cfg_write(mte_pkg::CFG_BLANK_SYMBOL, blank);
        cfg_write(mte_pkg::CFG_TAPE_COUNT, tapes);
        cfg_write(mte_pkg::CFG_ENTRY_COUNT, entries);
        cfg_write(mte_pkg::CFG_STEP_LIMIT, limit);
    endtask

    // empty table, cell extremes, clear, ignored funcs
    task automatic test_cells();
        configure(8'h10, 8'h00, 2'd2, 9'd0, 32'd0);
        cell_req(mte_pkg::FUNC_RUN, 0, 0);
        cell_req(mte_pkg::FUNC_READ, -512, 0);
        cell_req(mte_pkg::FUNC_WRITE, -512, 8'hFF);
        cell_req(mte_pkg::FUNC_WRITE, 511, 8'hA5);
        cell_req(mte_pkg::FUNC_READ, -512, 0);
        cell_req(mte_pkg::FUNC_READ, 511, 0);
        cell_req(mte_pkg::FUNC_READ, 0, 0);
        send(noise_req(3'd5));
        send(noise_req(3'd6));
        send(noise_req(3'd7));
        cell_req(mte_pkg::FUNC_CLEAR, 0, 0);
        cell_req(mte_pkg::FUNC_READ, 511, 0);
        drain();
    endtask

    // wildcard match and keep, stay move, limit beating no-match, tape 2 reblank
    task automatic test_wildcard_limit();
        configure(8'd1, 8'h20, 2'd2, 9'd3, 32'd0);
        cell_req(mte_pkg::FUNC_WRITE, 0, 8'h41);
        cell_req(mte_pkg::FUNC_WRITE, 1, 8'h42);
        load(0, 1, 1, mte_pkg::WILDCARD, 8'h20, mte_pkg::WILDCARD, 8'h51,
             mte_pkg::MOVE_RIGHT, mte_pkg::MOVE_RIGHT);
        load(1, 1, 7, 8'h20, mte_pkg::WILDCARD, 8'h5A, mte_pkg::WILDCARD, 2'd3, 2'd0);
        load(2, 7, 7, 8'h5A, 8'h20, 8'h20, 8'h51, mte_pkg::MOVE_LEFT, 2'd3);
        cell_req(mte_pkg::FUNC_RUN, 0, 0);
        cell_req(mte_pkg::FUNC_READ, 0, 0);
        cell_req(mte_pkg::FUNC_READ, 2, 0);
        drain();
        cfg_write(mte_pkg::CFG_STEP_LIMIT, 32'd2);
        cell_req(mte_pkg::FUNC_CLEAR, 0, 0);
        cell_req(mte_pkg::FUNC_WRITE, 0, 8'h41);
        cell_req(mte_pkg::FUNC_WRITE, 1, 8'h42);
        cell_req(mte_pkg::FUNC_RUN, 0, 0);
        cell_req(mte_pkg::FUNC_RUN, 0, 0);
        drain();
    endtask

    // heads walking off both ends of the window, register extremes
    task automatic test_window();
        configure(8'hFF, 8'hFF, 2'd2, 9'd1, 32'hFFFF_FFFF);
        load(0, 8'hFF, 8'hFF, 8'hFF, 8'hFF, mte_pkg::WILDCARD, mte_pkg::WILDCARD,
             mte_pkg::MOVE_LEFT, mte_pkg::MOVE_RIGHT);
        cell_req(mte_pkg::FUNC_RUN, 0, 0);
        drain();
        cfg_write(mte_pkg::CFG_TAPE_COUNT, 2'd3);
        load(0, 8'hFF, 8'h00, 8'hFF, 8'hFF, mte_pkg::WILDCARD, 8'h00,
             mte_pkg::MOVE_RIGHT, mte_pkg::MOVE_LEFT);
        load(1, 8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, mte_pkg::MOVE_RIGHT, 2'd0);
        cfg_write(mte_pkg::CFG_ENTRY_COUNT, 9'd2);
        cell_req(mte_pkg::FUNC_RUN, 0, 0);
        drain();
    endtask

    task automatic test_full_table();
        configure(8'd0, 8'd0, 2'd0, 9'd256, 32'd6);
        for (int i = 0; i < 256; i++)
            load(i, $urandom_range(0, 3), $urandom_range(0, 3), $urandom_range(0, 1),
                 $urandom_range(0, 1), $urandom, $urandom, $urandom, $urandom);
        cell_req(mte_pkg::FUNC_RUN, 0, 0);
        drain();
        configure(8'd2, 8'd1, 2'd2, 9'd511, 32'd4);
        cell_req(mte_pkg::FUNC_RUN, 0, 0);
        cell_req(mte_pkg::FUNC_READ, 1, 0);
        drain();
    endtask

    // result side stalls long, input side must back up
    task automatic test_backpressure();
        rx_long = 400;
        no_idle = 1;
        for (int i = 0; i < 8; i++) cell_req(mte_pkg::FUNC_READ, $urandom_range(0, 3) - 1, 0);
        no_idle = 0;
        drain();
    endtask

    function automatic logic [7:0] pick_sym();
        case ($urandom_range(0, 3))
            0: return blank_r;
            1: return mte_pkg::WILDCARD;
            2: return 8'h30 + $urandom_range(0, 2);
            default: return $urandom;
        endcase
    endfunction

    task automatic test_random_programs();
        int k;
        bit walk;
        while (n_items < 340) begin
            k = $urandom_range(1, 8);
            walk = ($urandom_range(0, 5) == 0);
            no_idle = ($urandom_range(0, 4) == 0);
            configure($urandom_range(0, 3),
                      ($urandom_range(0, 3) == 0) ? mte_pkg::WILDCARD : $urandom,
                      $urandom_range(0, 3), $urandom_range(0, k),
                      walk ? 32'd0 : $urandom_range(1, 40));
            for (int i = 0; i < k; i++)
                load(i, $urandom_range(0, 3), $urandom_range(0, 3), pick_sym(), pick_sym(),
                     pick_sym(), pick_sym(),
                     walk ? mte_pkg::MOVE_RIGHT : 2'($urandom_range(0, 3)),
                     $urandom_range(0, 3));
            repeat ($urandom_range(0, 5))
                cell_req(mte_pkg::FUNC_WRITE, $urandom_range(0, 8) - 4, pick_sym());
            if ($urandom_range(0, 3) == 0)
                cell_req(mte_pkg::FUNC_WRITE, $urandom_range(0, 1023) - 512, $urandom);
            if ($urandom_range(0, 5) == 0) send(noise_req($urandom_range(5, 7)));
            if ($urandom_range(0, 7) == 0) send(noise_req(mte_pkg::FUNC_LOAD));
            cell_req(mte_pkg::FUNC_RUN, 0, 0);
            repeat ($urandom_range(1, 3))
                cell_req(mte_pkg::FUNC_READ, $urandom_range(0, 8) - 4, 0);
            if ($urandom_range(0, 3) == 0)
                cell_req(mte_pkg::FUNC_READ, $urandom_range(0, 1023) - 512, 0);
            if ($urandom_range(0, 5) == 0) cell_req(mte_pkg::FUNC_CLEAR, 0, 0);
            drain();
        end
        no_idle = 0;
    endtask

    initial begin
        s_valid = 0; s_func = 0; s_entry_index = 0; s_match_state = 0; s_next_state = 0;
        s_expect_first = 0; s_expect_second = 0; s_write_first = 0; s_write_second = 0;
        s_move_first = 0; s_move_second = 0; s_cell_position = 0; s_cell_symbol = 0;
        cfg_wr_en = 0; cfg_index = 0; cfg_wdata = 0; m_ready = 0;
        rx_wait = 0; rx_long = 0; no_idle = 0; errors = 0; idle_cycles = 0;
        init_state_r = 0; blank_r = 0; tapes_r = 1; entries_r = 0; limit_r = 0;
        foreach (prog[i]) prog[i] = '0;
        foreach (tape_set[t, i]) begin
            tape_set[t][i] = 0;
            tape_sym[t][i] = 0;
        end
        aresetn = 0;
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1;
        repeat (SETTLE) @(posedge aclk);

        test_cells();
        test_wildcard_limit();
        test_window();
        test_backpressure();
        test_random_programs();
        test_full_table();
        drain();

        $display("covered %0d requests: %0d runs and %0d cell reads checked", n_items,
                 n_runs, n_reads);
        $display("mismatches: %0d, results still owed: %0d", errors, result_q.size());
        if (errors == 0 && result_q.size() == 0) begin
            $display("tb_multitape_turing_engine: PASS");
        end else begin
            $display("tb_multitape_turing_engine: FAIL");
        end
        $finish;
    end

endmodule
